/* rtl/core/obef_pkg.sv */
// Shared types, constants and helpers for the oriented box extent fit block.
// Used by obef_ctrl, obef_datapath and oriented_box_extent_fit; no dependencies.
`timescale 1ns / 1ps

package obef_pkg;

    // Field widths.
    localparam int COORD_WIDTH     = 16;
    localparam int AXIS_WIDTH      = 16;
    localparam int AXIS_REG_WIDTH  = 3 * AXIS_WIDTH;
    localparam int EXT_WIDTH       = 18;
    localparam int OUT_WIDTH       = 20;
    localparam int ITEM_WIDTH      = 4;
    localparam int COMP_WIDTH      = 2;
    localparam int CFG_INDEX_WIDTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_AXIS_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_AXIS_SECOND = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_AXIS_THIRD  = 2'd2;

    // Reset axes: the unit x, y and z vectors in Q1.14.
    localparam logic [AXIS_REG_WIDTH-1:0] AXIS_FIRST_RESET  = 48'h0000_0000_4000;
    localparam logic [AXIS_REG_WIDTH-1:0] AXIS_SECOND_RESET = 48'h0000_4000_0000;
    localparam logic [AXIS_REG_WIDTH-1:0] AXIS_THIRD_RESET  = 48'h4000_0000_0000;

    // Result item codes.
    localparam logic [ITEM_WIDTH-1:0] ITEM_CENTRE       = 4'd0;
    localparam logic [ITEM_WIDTH-1:0] ITEM_HALF_WIDTH   = 4'd1;
    localparam logic [ITEM_WIDTH-1:0] ITEM_CORNER_FIRST = 4'd2;
    localparam logic [ITEM_WIDTH-1:0] ITEM_LAST         = 4'd9;

    // Vector component codes.
    localparam logic [COMP_WIDTH-1:0] COMP_X = 2'd0;
    localparam logic [COMP_WIDTH-1:0] COMP_Y = 2'd1;
    localparam logic [COMP_WIDTH-1:0] COMP_Z = 2'd2;

    // Saturation bounds.
    localparam logic signed [EXT_WIDTH-1:0] EXT_MAX = 18'sh1FFFF;
    localparam logic signed [EXT_WIDTH-1:0] EXT_MIN = 18'sh20000;
    localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = 20'sh7FFFF;
    localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = 20'sh80000;

    // One input word: a point and its end-of-set mark.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
        logic                          final_point;
    } point_word_t;

    // One result word.
    typedef struct packed {
        logic        [ITEM_WIDTH-1:0] item_index;
        logic signed [OUT_WIDTH-1:0]  value_x;
        logic signed [OUT_WIDTH-1:0]  value_y;
        logic signed [OUT_WIDTH-1:0]  value_z;
        logic                         run_end;
    } result_word_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_POINTS,
        ST_FLUSH,
        ST_HALF,
        ST_MUL,
        ST_ACC,
        ST_HALF_OUT,
        ST_OUT
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                  prep;
        logic                  mul;
        logic                  acc;
        logic                  load_half;
        logic                  clear;
        logic [ITEM_WIDTH-1:0] item;
        logic [COMP_WIDTH-1:0] comp;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;
    } dp_status_t;

    // Corner sign pattern: bit i set means the half width of axis i is added.
    function automatic logic [2:0] corner_pos(input logic [2:0] corner);
        logic [2:0] pos;
        unique case (corner)
            3'd0:    pos = 3'b000;
            3'd1:    pos = 3'b001;
            3'd2:    pos = 3'b101;
            3'd3:    pos = 3'b100;
            3'd4:    pos = 3'b010;
            3'd5:    pos = 3'b011;
            3'd6:    pos = 3'b111;
            default: pos = 3'b110;
        endcase
        return pos;
    endfunction

endpackage

/* rtl/core/obef_ctrl.sv */
// Controller of the oriented box extent fit: point intake, flush and result sequencing.
// Depends on obef_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps

module obef_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 point_valid,
    input  logic                 point_final,
    output logic                 point_stall,
    output logic                 result_valid,
    input  logic                 result_stall,
    input  obef_pkg::dp_status_t status,
    output obef_pkg::dp_cmd_t    cmd
);

    obef_pkg::ctl_state_t                state_reg, state_next;
    logic [obef_pkg::ITEM_WIDTH-1:0]     item_reg, item_next;
    logic [obef_pkg::COMP_WIDTH-1:0]     comp_reg, comp_next;

    // State, item and component registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= obef_pkg::ST_POINTS;
            item_reg  <= obef_pkg::ITEM_CENTRE;
            comp_reg  <= obef_pkg::COMP_X;
        end
        else
        begin
            state_reg <= state_next;
            item_reg  <= item_next;
            comp_reg  <= comp_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        comp_next    = comp_reg;
        cmd          = '0;
        cmd.item     = item_reg;
        cmd.comp     = comp_reg;
        point_stall  = 1'b1;
        result_valid = 1'b0;
        unique case (state_reg)
            obef_pkg::ST_POINTS:
            begin
                point_stall = 1'b0;
                if (point_valid && point_final)
                begin
                    state_next = obef_pkg::ST_FLUSH;
                end
            end
            obef_pkg::ST_FLUSH:
            begin
                // Wait until the final point has reached the extents.
                if (!status.pipe_busy)
                begin
                    state_next = obef_pkg::ST_HALF;
                end
            end
            obef_pkg::ST_HALF:
            begin
                cmd.prep   = 1'b1;
                item_next  = obef_pkg::ITEM_CENTRE;
                comp_next  = obef_pkg::COMP_X;
                state_next = obef_pkg::ST_MUL;
            end
            obef_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = obef_pkg::ST_ACC;
            end
            obef_pkg::ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (comp_reg == obef_pkg::COMP_Z)
                begin
                    comp_next  = obef_pkg::COMP_X;
                    state_next = obef_pkg::ST_OUT;
                end
                else
                begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = obef_pkg::ST_MUL;
                end
            end
            obef_pkg::ST_HALF_OUT:
            begin
                cmd.load_half = 1'b1;
                state_next    = obef_pkg::ST_OUT;
            end
            obef_pkg::ST_OUT:
            begin
                result_valid = 1'b1;
                if (!result_stall)
                begin
                    if (item_reg == obef_pkg::ITEM_LAST)
                    begin
                        cmd.clear  = 1'b1;
                        item_next  = obef_pkg::ITEM_CENTRE;
                        state_next = obef_pkg::ST_POINTS;
                    end
                    else
                    begin
                        item_next = item_reg + 1'b1;
                        if (item_reg == obef_pkg::ITEM_CENTRE)
                        begin
                            state_next = obef_pkg::ST_HALF_OUT;
                        end
                        else
                        begin
                            state_next = obef_pkg::ST_MUL;
                        end
                    end
                end
            end
            default:
            begin
                state_next = obef_pkg::ST_POINTS;
            end
        endcase
    end

endmodule

/* rtl/core/obef_datapath.sv */
// Datapath of the oriented box extent fit: axis registers, projection pipeline,
// extents, and the shared three-multiplier unit for centre and corners. Uses obef_pkg.
`timescale 1ns / 1ps

module obef_datapath #(
    parameter int AXIS_FRAC_BITS = 14
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [obef_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [obef_pkg::AXIS_REG_WIDTH-1:0]     cfg_data,
    input  logic                                    point_accept,
    input  obef_pkg::point_word_t                   point_data,
    input  obef_pkg::dp_cmd_t                       cmd,
    output obef_pkg::dp_status_t                    status,
    output obef_pkg::result_word_t                  result_data
);

    localparam int AW           = obef_pkg::AXIS_WIDTH;
    localparam int CW           = obef_pkg::COORD_WIDTH;
    localparam int EW           = obef_pkg::EXT_WIDTH;
    localparam int OW           = obef_pkg::OUT_WIDTH;
    localparam int PROD_WIDTH   = AW + CW;
    localparam int PSUM_WIDTH   = PROD_WIDTH + 2;
    localparam int EPROD_WIDTH  = AW + EW;
    localparam int ESUM_WIDTH   = EPROD_WIDTH + 2;
    localparam int CORNER_WIDTH = ESUM_WIDTH + 1;

    logic [obef_pkg::AXIS_REG_WIDTH-1:0] axis_reg [3];
    logic signed [AW-1:0]                axis_c [3][3];
    logic signed [CW-1:0]                pt [3];

    logic signed [PROD_WIDTH-1:0]  pprod_reg [3][3];
    logic signed [EW-1:0]          proj_reg [3];
    logic signed [EW-1:0]          proj_next [3];
    logic                          v1_reg, v2_reg;
    logic signed [EW-1:0]          upper_reg [3];
    logic signed [EW-1:0]          lower_reg [3];
    logic signed [EW-1:0]          hw_reg [3];
    logic signed [EW-1:0]          mid_reg [3];
    logic signed [EW-1:0]          hw_next [3];
    logic signed [EW-1:0]          mid_next [3];
    logic signed [EW-1:0]          op [3];
    logic signed [EPROD_WIDTH-1:0] eprod_reg [3];
    logic signed [ESUM_WIDTH-1:0]  cen_reg [3];
    logic signed [OW-1:0]          vec_reg [3];
    logic signed [ESUM_WIDTH-1:0]  esum, eshift, cen_src;
    logic signed [CORNER_WIDTH-1:0] corner_sum;
    logic [obef_pkg::ITEM_WIDTH-1:0] corner;
    logic [2:0]                    pos;

    // Saturate a centre or corner sum to the output width.
    function automatic logic signed [OW-1:0] sat_out(input logic signed [CORNER_WIDTH-1:0] v);
        logic signed [OW-1:0] r;
        if (v > CORNER_WIDTH'(obef_pkg::OUT_MAX))
            r = obef_pkg::OUT_MAX;
        else if (v < CORNER_WIDTH'(obef_pkg::OUT_MIN))
            r = obef_pkg::OUT_MIN;
        else
            r = v[OW-1:0];
        return r;
    endfunction

    // Axis configuration registers; a write to an unused index is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg[0] <= obef_pkg::AXIS_FIRST_RESET;
            axis_reg[1] <= obef_pkg::AXIS_SECOND_RESET;
            axis_reg[2] <= obef_pkg::AXIS_THIRD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                obef_pkg::CFG_AXIS_FIRST:  axis_reg[0] <= cfg_data;
                obef_pkg::CFG_AXIS_SECOND: axis_reg[1] <= cfg_data;
                obef_pkg::CFG_AXIS_THIRD:  axis_reg[2] <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Split the axes into signed components and the point into coordinates.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                axis_c[i][j] = axis_reg[i][j*AW +: AW];
            end
        end
        pt[0] = point_data.point_x;
        pt[1] = point_data.point_y;
        pt[2] = point_data.point_z;
    end

    // Projection stage one: nine products of axis components and coordinates.
    always_ff @(posedge clk)
    begin
        if (point_accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    pprod_reg[i][j] <= axis_c[i][j] * pt[j];
                end
            end
        end
    end

    // Projection stage two: sum, floor shift and saturate to the extent width.
    always_comb
    begin
        logic signed [PSUM_WIDTH-1:0] psum;
        logic signed [PSUM_WIDTH-1:0] pshift;
        for (int i = 0; i < 3; i++)
        begin
            psum = PSUM_WIDTH'(pprod_reg[i][0]) + PSUM_WIDTH'(pprod_reg[i][1])
                 + PSUM_WIDTH'(pprod_reg[i][2]);
            pshift = psum >>> AXIS_FRAC_BITS;
            if (pshift > PSUM_WIDTH'(obef_pkg::EXT_MAX))
                proj_next[i] = obef_pkg::EXT_MAX;
            else if (pshift < PSUM_WIDTH'(obef_pkg::EXT_MIN))
                proj_next[i] = obef_pkg::EXT_MIN;
            else
                proj_next[i] = pshift[EW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            proj_reg <= proj_next;
        end
    end

    // Pipeline occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= point_accept;
            v2_reg <= v1_reg;
        end
    end

    assign status.pipe_busy = v1_reg | v2_reg;

    // Projection stage three: running extents, cleared after the last result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                upper_reg[i] <= obef_pkg::EXT_MIN;
                lower_reg[i] <= obef_pkg::EXT_MAX;
            end
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < 3; i++)
            begin
                upper_reg[i] <= obef_pkg::EXT_MIN;
                lower_reg[i] <= obef_pkg::EXT_MAX;
            end
        end
        else if (v2_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (proj_reg[i] > upper_reg[i])
                    upper_reg[i] <= proj_reg[i];
                if (proj_reg[i] < lower_reg[i])
                    lower_reg[i] <= proj_reg[i];
            end
        end
    end

    // Half widths and midpoints of the extents.
    always_comb
    begin
        logic signed [EW:0] ext_diff;
        logic signed [EW:0] ext_sum;
        for (int i = 0; i < 3; i++)
        begin
            ext_diff    = (EW + 1)'(upper_reg[i]) - (EW + 1)'(lower_reg[i]);
            ext_sum     = (EW + 1)'(upper_reg[i]) + (EW + 1)'(lower_reg[i]);
            hw_next[i]  = 18'(ext_diff >>> 1);
            mid_next[i] = 18'(ext_sum >>> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            hw_reg  <= hw_next;
            mid_reg <= mid_next;
        end
    end

    // Operands of the shared unit: midpoints for the centre, signed half widths
    // for a corner.
    always_comb
    begin
        corner = cmd.item - obef_pkg::ITEM_CORNER_FIRST;
        pos    = obef_pkg::corner_pos(corner[2:0]);
        for (int i = 0; i < 3; i++)
        begin
            if (cmd.item == obef_pkg::ITEM_CENTRE)
                op[i] = mid_reg[i];
            else if (pos[i])
                op[i] = hw_reg[i];
            else
                op[i] = -hw_reg[i];
        end
    end

    // Shared unit, multiply step: column comp of the axes times the operands.
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            for (int i = 0; i < 3; i++)
            begin
                eprod_reg[i] <= axis_c[i][cmd.comp] * op[i];
            end
        end
    end

    // Shared unit, accumulate step: sum, floor shift, add the centre, saturate.
    always_comb
    begin
        esum = ESUM_WIDTH'(eprod_reg[0]) + ESUM_WIDTH'(eprod_reg[1])
             + ESUM_WIDTH'(eprod_reg[2]);
        eshift = esum >>> AXIS_FRAC_BITS;
        if (cmd.item == obef_pkg::ITEM_CENTRE)
            cen_src = '0;
        else
            cen_src = cen_reg[cmd.comp];
        corner_sum = CORNER_WIDTH'(cen_src) + CORNER_WIDTH'(eshift);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc)
        begin
            if (cmd.item == obef_pkg::ITEM_CENTRE)
                cen_reg[cmd.comp] <= eshift;
            vec_reg[cmd.comp] <= sat_out(corner_sum);
        end
        else if (cmd.load_half)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vec_reg[i] <= OW'(hw_reg[i]);
            end
        end
    end

    // Output word; it holds while the controller presents it.
    always_comb
    begin
        result_data.item_index = cmd.item;
        result_data.value_x    = vec_reg[0];
        result_data.value_y    = vec_reg[1];
        result_data.value_z    = vec_reg[2];
        result_data.run_end    = (cmd.item == obef_pkg::ITEM_LAST);
    end

endmodule

/* rtl/core/oriented_box_extent_fit.sv */
// Top level of the oriented box extent fit: joins controller and datapath.
// Depends on obef_pkg, obef_ctrl and obef_datapath.
`timescale 1ns / 1ps

// Usage.
// Points enter on the point channel (point_valid, point_stall, point_data), one
// word per cycle while the block collects a set. Each point is projected onto the
// three axes held in the configuration registers, and the running extents update once
// the point has passed the product and projection registers. A word with final_point
// set closes the set. After the final point the block raises point_stall and produces
// ten result words on the result channel: the centre, the half widths and eight
// corners, the last one flagged by run_end. Once the extents have settled, the half
// widths and midpoints are registered; the shared three-multiplier unit then forms the
// centre and each corner one vector component at a time, in a multiply step and an
// accumulate step; the half widths load directly. After the run, intake reopens.
// When the receiver holds result_stall, the presented word holds and the sequence
// waits. The configuration port (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; writes to an index beyond the third axis are dropped.
// Reset loads the unit x, y and z axes, clears the extents and returns to point intake.
module oriented_box_extent_fit #(
    parameter int AXIS_FRAC_BITS = 14
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 point_valid,
    output logic                                 point_stall,
    input  obef_pkg::point_word_t                point_data,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output obef_pkg::result_word_t               result_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [obef_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [obef_pkg::AXIS_REG_WIDTH-1:0]  cfg_data
);

    obef_pkg::dp_cmd_t    cmd;
    obef_pkg::dp_status_t status;
    logic                 point_accept;
    logic                 cfg_write;

    assign cfg_ready    = 1'b1;
    assign cfg_write    = cfg_valid & cfg_ready;
    assign point_accept = point_valid & ~point_stall;

    // Sequencer.
    obef_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_final  (point_data.final_point),
        .point_stall  (point_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // Arithmetic and storage.
    obef_datapath #(
        .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .point_accept (point_accept),
        .point_data   (point_data),
        .cmd          (cmd),
        .status       (status),
        .result_data  (result_data)
    );

    // The end mark sits on the last item only.
    a_run_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.run_end == (result_data.item_index == obef_pkg::ITEM_LAST)))
        else $error("run_end does not match the last item");

    // No point is taken while results are presented.
    a_no_point_during_results: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> point_stall)
        else $error("point intake open while results are presented");

    // Intake closes right after the final point.
    a_stall_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (point_accept && point_data.final_point) |=> point_stall)
        else $error("intake still open after the final point");

    // After the last result is taken the result channel goes quiet.
    a_quiet_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && result_data.run_end) |=> !result_valid)
        else $error("result presented after the end of the run");

endmodule

/* verif/obef_box_checker.sv */
// Checker for the oriented box extent fit: predicts every result word and compares it.
// Depends on obef_pkg; watches the point, result and configuration channels of the block.
`timescale 1ns / 1ps

module obef_box_checker #(
    parameter int AXIS_FRAC_BITS = 14
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 point_valid,
    input  logic                                 point_stall,
    input  obef_pkg::point_word_t                point_data,
    input  logic                                 result_valid,
    input  logic                                 result_stall,
    input  obef_pkg::result_word_t               result_data,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [obef_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [obef_pkg::AXIS_REG_WIDTH-1:0]  cfg_data,
    output int                                   fail_count,
    output int                                   pending
);

    // Positive half-width mask per corner, three bits per corner, corner zero lowest.
    localparam logic [23:0] CORNER_PLUS =
        {3'b110, 3'b111, 3'b011, 3'b010, 3'b100, 3'b101, 3'b001, 3'b000};

    // Shadow of the axis registers and the running extents.
    logic [obef_pkg::AXIS_REG_WIDTH-1:0]   axis_row [3];
    logic signed [obef_pkg::EXT_WIDTH-1:0] extent_hi [3];
    logic signed [obef_pkg::EXT_WIDTH-1:0] extent_lo [3];
    obef_pkg::result_word_t                expected_box_words [$];
    int                                    mismatch_total = 0;

    function automatic longint axis_comp(input int row, input int col);
        logic signed [obef_pkg::AXIS_WIDTH-1:0] c;
        c = axis_row[row][obef_pkg::AXIS_WIDTH*col +: obef_pkg::AXIS_WIDTH];
        return longint'(c);
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic clear_extents();
        int i;
        for (i = 0; i < 3; i++)
        begin
            extent_hi[i] = obef_pkg::EXT_MIN;
            extent_lo[i] = obef_pkg::EXT_MAX;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] box check: %s got %0d expected %0d", $time, what, got, want);
        mismatch_total++;
    endtask

    task automatic queue_word(input logic [obef_pkg::ITEM_WIDTH-1:0] item, input longint vx,
                              input longint vy, input longint vz);
        obef_pkg::result_word_t w;
        w.item_index = item;
        w.value_x    = vx[obef_pkg::OUT_WIDTH-1:0];
        w.value_y    = vy[obef_pkg::OUT_WIDTH-1:0];
        w.value_z    = vz[obef_pkg::OUT_WIDTH-1:0];
        w.run_end    = (item == obef_pkg::ITEM_LAST);
        expected_box_words.push_back(w);
    endtask

    // Project one point onto the three axes and widen the extents.
    task automatic absorb_point(input obef_pkg::point_word_t w);
        longint coord [3];
        longint dot;
        longint proj;
        int     i;
        int     j;
        coord[0] = longint'(w.point_x);
        coord[1] = longint'(w.point_y);
        coord[2] = longint'(w.point_z);
        for (i = 0; i < 3; i++)
        begin
            dot = 0;
            for (j = 0; j < 3; j++)
                dot += axis_comp(i, j) * coord[j];
            proj = clamp(dot >>> AXIS_FRAC_BITS, obef_pkg::EXT_MIN, obef_pkg::EXT_MAX);
            if (proj > extent_hi[i])
                extent_hi[i] = proj[obef_pkg::EXT_WIDTH-1:0];
            if (proj < extent_lo[i])
                extent_lo[i] = proj[obef_pkg::EXT_WIDTH-1:0];
        end
    endtask

    // Close a set: centre, half widths and the eight corners, then clear the extents.
    task automatic emit_box_words();
        longint half [3];
        longint mid [3];
        longint centre [3];
        longint corner [3];
        longint dot;
        logic [2:0] plus;
        int     i;
        int     j;
        int     k;
        for (i = 0; i < 3; i++)
        begin
            half[i] = (longint'(extent_hi[i]) - longint'(extent_lo[i])) >>> 1;
            mid[i]  = (longint'(extent_hi[i]) + longint'(extent_lo[i])) >>> 1;
        end
        // The centre maps the midpoint back through the transposed axes.
        for (j = 0; j < 3; j++)
        begin
            dot = 0;
            for (i = 0; i < 3; i++)
                dot += axis_comp(i, j) * mid[i];
            centre[j] = dot >>> AXIS_FRAC_BITS;
        end
        queue_word(obef_pkg::ITEM_CENTRE,
                   clamp(centre[0], obef_pkg::OUT_MIN, obef_pkg::OUT_MAX),
                   clamp(centre[1], obef_pkg::OUT_MIN, obef_pkg::OUT_MAX),
                   clamp(centre[2], obef_pkg::OUT_MIN, obef_pkg::OUT_MAX));
        queue_word(obef_pkg::ITEM_HALF_WIDTH, half[0], half[1], half[2]);
        // Corners add the signed half widths, also through the transposed axes.
        for (k = 0; k < 8; k++)
        begin
            plus = CORNER_PLUS[3*k +: 3];
            for (j = 0; j < 3; j++)
            begin
                dot = 0;
                for (i = 0; i < 3; i++)
                    dot += axis_comp(i, j) * (plus[i] ? half[i] : -half[i]);
                corner[j] = clamp(centre[j] + (dot >>> AXIS_FRAC_BITS),
                                  obef_pkg::OUT_MIN, obef_pkg::OUT_MAX);
            end
            queue_word(obef_pkg::ITEM_CORNER_FIRST + obef_pkg::ITEM_WIDTH'(k),
                       corner[0], corner[1], corner[2]);
        end
        clear_extents();
    endtask

    // Compare one accepted result word with the oldest expectation.
    task automatic check_result(input obef_pkg::result_word_t got);
        obef_pkg::result_word_t want;
        if (expected_box_words.size() == 0)
        begin
            report_mismatch("result word with nothing pending, item", got.item_index, -1);
            return;
        end
        want = expected_box_words.pop_front();
        if (got.item_index != want.item_index)
            report_mismatch("item_index", got.item_index, want.item_index);
        if (got.value_x != want.value_x)
            report_mismatch($sformatf("item %0d value_x", want.item_index),
                            longint'(got.value_x), longint'(want.value_x));
        if (got.value_y != want.value_y)
            report_mismatch($sformatf("item %0d value_y", want.item_index),
                            longint'(got.value_y), longint'(want.value_y));
        if (got.value_z != want.value_z)
            report_mismatch($sformatf("item %0d value_z", want.item_index),
                            longint'(got.value_z), longint'(want.value_z));
        if (got.run_end != want.run_end)
            report_mismatch($sformatf("item %0d run_end", want.item_index),
                            got.run_end, want.run_end);
    endtask

    // Watch all three channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_row[0] = obef_pkg::AXIS_FIRST_RESET;
            axis_row[1] = obef_pkg::AXIS_SECOND_RESET;
            axis_row[2] = obef_pkg::AXIS_THIRD_RESET;
            clear_extents();
            expected_box_words.delete();
            pending    <= 0;
            fail_count <= mismatch_total;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_result(result_data);
            if (cfg_valid && cfg_ready && cfg_index <= obef_pkg::CFG_AXIS_THIRD)
                axis_row[cfg_index] = cfg_data;
            if (point_valid && !point_stall)
            begin
                absorb_point(point_data);
                if (point_data.final_point)
                    emit_box_words();
            end
            pending    <= expected_box_words.size();
            fail_count <= mismatch_total;
        end
    end

endmodule

/* verif/tb_oriented_box_extent_fit.sv */
// Testbench top for the oriented box extent fit: clock, reset, stimulus and verdict.
// Depends on obef_pkg, the block oriented_box_extent_fit and the checker obef_box_checker.
`timescale 1ns / 1ps

module tb_oriented_box_extent_fit;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int POINT_TARGET  = 470;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int TAIL_CYCLES   = 80;

    // Index past the last axis register; writes to it are dropped by the block.
    localparam logic [obef_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 2'd3;

    // Q1.14 component values.
    localparam logic [obef_pkg::AXIS_WIDTH-1:0] Q_ONE      = 16'h4000;
    localparam logic [obef_pkg::AXIS_WIDTH-1:0] Q_NEG_ONE  = 16'hC000;
    localparam logic [obef_pkg::AXIS_WIDTH-1:0] Q_MOST_NEG = 16'h8000;
    localparam logic [obef_pkg::AXIS_WIDTH-1:0] Q_MOST_POS = 16'h7FFF;

    localparam logic [obef_pkg::COORD_WIDTH-1:0] C_MOST_NEG = 16'h8000;
    localparam logic [obef_pkg::COORD_WIDTH-1:0] C_MOST_POS = 16'h7FFF;

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 point_valid;
    logic                                 point_stall;
    obef_pkg::point_word_t                point_data;
    logic                                 result_valid;
    logic                                 result_stall;
    obef_pkg::result_word_t               result_data;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [obef_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [obef_pkg::AXIS_REG_WIDTH-1:0]  cfg_data;

    int  fail_count;
    int  pending;
    int  cycle_count = 0;
    int  points_sent = 0;
    bit  steady = 1'b0;
    int  long_hold_reqs = 0;

    oriented_box_extent_fit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point_data   (point_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    obef_box_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point_data   (point_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Idle length: mostly none, sometimes a few cycles, now and then a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [obef_pkg::COORD_WIDTH-1:0] random_coord();
        case ($urandom_range(0, 9))
            0:       return C_MOST_NEG;
            1:       return C_MOST_POS;
            2, 3, 4: return obef_pkg::COORD_WIDTH'($urandom_range(0, 200))
                            - obef_pkg::COORD_WIDTH'(100);
            default: return obef_pkg::COORD_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [obef_pkg::AXIS_REG_WIDTH-1:0] random_axis();
        logic [obef_pkg::AXIS_REG_WIDTH-1:0] row;
        int                                  c;
        row = '0;
        for (c = 0; c < 3; c++)
        begin
            case ($urandom_range(0, 5))
                0:       row[obef_pkg::AXIS_WIDTH*c +: obef_pkg::AXIS_WIDTH] = Q_ONE;
                1:       row[obef_pkg::AXIS_WIDTH*c +: obef_pkg::AXIS_WIDTH] = Q_NEG_ONE;
                2:       row[obef_pkg::AXIS_WIDTH*c +: obef_pkg::AXIS_WIDTH] =
                             $urandom_range(0, 1) ? Q_MOST_NEG : Q_MOST_POS;
                3:       row[obef_pkg::AXIS_WIDTH*c +: obef_pkg::AXIS_WIDTH] =
                             obef_pkg::AXIS_WIDTH'($urandom);
                default: row[obef_pkg::AXIS_WIDTH*c +: obef_pkg::AXIS_WIDTH] =
                             obef_pkg::AXIS_WIDTH'($urandom_range(0, 32768)) - Q_ONE;
            endcase
        end
        return row;
    endfunction

    function automatic int set_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(1, 4);
        if (r < 90)
            return $urandom_range(5, 12);
        return $urandom_range(13, 40);
    endfunction

    // Offer one point word and hold it until the block takes it.
    task automatic send_point(input logic [obef_pkg::COORD_WIDTH-1:0] x,
                              input logic [obef_pkg::COORD_WIDTH-1:0] y,
                              input logic [obef_pkg::COORD_WIDTH-1:0] z, input logic fin);
        obef_pkg::point_word_t w;
        int                    gap;
        w.point_x     = x;
        w.point_y     = y;
        w.point_z     = z;
        w.final_point = fin;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            point_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_valid <= 1'b1;
        point_data  <= w;
        do
            @(posedge clk);
        while (point_stall);
        points_sent++;
    endtask

    task automatic send_set(input int n);
        int k;
        for (k = 0; k < n; k++)
            send_point(random_coord(), random_coord(), random_coord(), k == n - 1);
    endtask

    // Leaves cfg_valid high so that back-to-back writes need no toggle; callers lower it.
    task automatic write_axis(input logic [obef_pkg::CFG_INDEX_WIDTH-1:0] idx,
                              input logic [obef_pkg::AXIS_REG_WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic write_all_axes(input logic [obef_pkg::AXIS_WIDTH-1:0] comp);
        write_axis(obef_pkg::CFG_AXIS_FIRST, {3{comp}});
        write_axis(obef_pkg::CFG_AXIS_SECOND, {3{comp}});
        write_axis(obef_pkg::CFG_AXIS_THIRD, {3{comp}});
        cfg_valid <= 1'b0;
    endtask

    // Stop offering points until every pending result word has come out.
    task automatic wait_drained();
        point_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: random stalls except in steady phases, and a long hold-off on request.
    initial
    begin : receiver
        int stall_left;
        int holds_taken;
        stall_left  = 0;
        holds_taken = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                result_stall <= 1'b0;
                if (long_hold_reqs != holds_taken)
                begin
                    stall_left  = LONG_HOLD;
                    holds_taken = long_hold_reqs;
                end
                else if (!steady)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin : stimulus
        int phase;
        int sets_left;
        rst_n       <= 1'b0;
        point_valid <= 1'b0;
        point_data  <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= obef_pkg::CFG_AXIS_FIRST;
        cfg_data    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset axes: a one-point set at the origin, then a set at the coordinate extremes.
        steady = 1'b1;
        send_point('0, '0, '0, 1'b1);
        send_point(C_MOST_POS, C_MOST_NEG, C_MOST_POS, 1'b0);
        send_point(C_MOST_NEG, C_MOST_POS, C_MOST_NEG, 1'b1);
        steady = 1'b0;
        wait_drained();

        // Most negative axis components: projections and outputs both saturate.
        write_all_axes(Q_MOST_NEG);
        send_point(C_MOST_NEG, C_MOST_NEG, C_MOST_NEG, 1'b0);
        send_point(C_MOST_POS, C_MOST_POS, C_MOST_POS, 1'b1);
        wait_drained();

        // Most positive axis components.
        write_all_axes(Q_MOST_POS);
        send_point(C_MOST_NEG, C_MOST_NEG, C_MOST_NEG, 1'b0);
        send_point(C_MOST_POS, C_MOST_POS, C_MOST_POS, 1'b0);
        send_point('0, '0, '0, 1'b1);
        wait_drained();

        // A write past the last register must leave the axes alone.
        write_axis(CFG_UNUSED, '1);
        cfg_valid <= 1'b0;
        send_point(16'd1, 16'd2, 16'd3, 1'b1);
        wait_drained();

        // All-zero axes collapse every projection to zero.
        write_all_axes('0);
        send_point(16'd5, -16'sd5, 16'd7, 1'b1);
        wait_drained();

        // Random phases: new axes, then a run of random sets.
        phase = 0;
        while (points_sent < POINT_TARGET)
        begin
            if (phase == 0 || $urandom_range(0, 2) != 0)
                write_axis(obef_pkg::CFG_AXIS_FIRST, random_axis());
            if (phase == 0 || $urandom_range(0, 2) != 0)
                write_axis(obef_pkg::CFG_AXIS_SECOND, random_axis());
            if (phase == 0 || $urandom_range(0, 2) != 0)
                write_axis(obef_pkg::CFG_AXIS_THIRD, random_axis());
            if ($urandom_range(0, 5) == 0)
                write_axis(CFG_UNUSED, random_axis());
            cfg_valid <= 1'b0;
            steady = (phase % 5 == 3);
            if (phase % 4 == 1)
                long_hold_reqs++;
            sets_left = $urandom_range(3, 8);
            while (sets_left > 0 && points_sent < POINT_TARGET)
            begin
                send_set(set_size());
                sets_left--;
            end
            wait_drained();
            phase++;
        end
        steady = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
